// File: src/gbn_pkg.sv
package gbn_pkg;

  localparam int CoordW     = 16;
  localparam int ScoreW     = 16;
  localparam int PickIdxW   = 6;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 16;

  localparam logic [CfgIdxW-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MODE      = 2'd1;

  localparam logic [CfgDataW-1:0] THR_RESET = 16'h8000;

  typedef struct packed {
    logic signed [CoordW-1:0] box_y2;
    logic signed [CoordW-1:0] box_x2;
    logic signed [CoordW-1:0] box_y1;
    logic signed [CoordW-1:0] box_x1;
  } corners_t;

  typedef struct packed {
    logic signed [CoordW-1:0] box_x1;
    logic signed [CoordW-1:0] box_y1;
    logic signed [CoordW-1:0] box_x2;
    logic signed [CoordW-1:0] box_y2;
    logic [ScoreW-1:0]        box_score;
    logic                     box_last;
  } box_in_t;

  typedef struct packed {
    logic [PickIdxW-1:0] picked_index;
    logic                picked_last;
    logic                overflow;
  } pick_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic pick_start;
    logic scan_clr;
    logic scan_pick;
    logic scan_supp;
    logic prep;
    logic emit;
    logic end_set;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_end;
    logic busy;
    logic any_left;
    logic out_free;
  } stat_t;

endpackage

// File: src/gbn_ctrl.sv
module gbn_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  output logic          in_ready_o,
  input  gbn_pkg::stat_t stat_i,
  output gbn_pkg::cmd_t  cmd_o
);
  import gbn_pkg::*;

  localparam logic [2:0] ST_LOAD       = 3'd0;
  localparam logic [2:0] ST_PICK       = 3'd1;
  localparam logic [2:0] ST_PICK_DRAIN = 3'd2;
  localparam logic [2:0] ST_PREP       = 3'd3;
  localparam logic [2:0] ST_SUPP       = 3'd4;
  localparam logic [2:0] ST_SUPP_DRAIN = 3'd5;
  localparam logic [2:0] ST_EMIT       = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    state_d    = state_q;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            cmd_o.scan_clr   = 1'b1;
            cmd_o.pick_start = 1'b1;
            state_d          = ST_PICK;
          end
        end
      end
      ST_PICK: begin
        cmd_o.scan_pick = 1'b1;
        if (stat_i.scan_end) begin
          state_d = ST_PICK_DRAIN;
        end
      end
      ST_PICK_DRAIN: begin
        if (!stat_i.busy) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep     = 1'b1;
        cmd_o.scan_clr = 1'b1;
        state_d        = ST_SUPP;
      end
      ST_SUPP: begin
        cmd_o.scan_supp = 1'b1;
        if (stat_i.scan_end) begin
          state_d = ST_SUPP_DRAIN;
        end
      end
      ST_SUPP_DRAIN: begin
        if (!stat_i.busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.any_left) begin
            cmd_o.scan_clr   = 1'b1;
            cmd_o.pick_start = 1'b1;
            state_d          = ST_PICK;
          end else begin
            cmd_o.end_set = 1'b1;
            state_d       = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: src/gbn_dp.sv
module gbn_dp #(
  parameter int MAX_BOXES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gbn_pkg::box_in_t              in_data_i,
  input  logic                          cfg_we_i,
  input  logic [gbn_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gbn_pkg::CfgDataW-1:0]  cfg_data_i,
  input  gbn_pkg::cmd_t                 cmd_i,
  output gbn_pkg::stat_t                stat_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output gbn_pkg::pick_out_t            out_data_o
);
  import gbn_pkg::*;

  localparam int IdxW = $clog2(MAX_BOXES);
  localparam int CntW = $clog2(MAX_BOXES + 1);

  // configuration
  logic [CfgDataW-1:0] thr_q;
  logic                mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THR_RESET;
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_THRESHOLD) begin
        thr_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_MODE) begin
        mode_q <= cfg_data_i[0];
      end
    end
  end

  // set bookkeeping
  logic [CntW-1:0]      count_q;
  logic                 ovf_q;
  logic                 full;
  logic                 wr_en;
  logic [IdxW-1:0]      wr_idx;

  assign full   = (count_q == CntW'(MAX_BOXES));
  assign wr_en  = cmd_i.load && !full;
  assign wr_idx = count_q[IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.end_set) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.load) begin
      if (full) begin
        ovf_q <= 1'b1;
      end else begin
        count_q <= count_q + CntW'(1);
      end
    end
  end

  // box stores
  corners_t          corner_mem [MAX_BOXES];
  logic [ScoreW-1:0] score_mem  [MAX_BOXES];
  corners_t          rd_corner_q;
  logic [ScoreW-1:0] rd_score_q;

  logic [IdxW-1:0] scan_idx_q;
  logic            rd_en;

  assign rd_en = cmd_i.scan_pick || cmd_i.scan_supp;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      corner_mem[wr_idx] <= '{box_y2: in_data_i.box_y2, box_x2: in_data_i.box_x2,
                              box_y1: in_data_i.box_y1, box_x1: in_data_i.box_x1};
      score_mem[wr_idx]  <= in_data_i.box_score;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_corner_q <= corner_mem[scan_idx_q];
      rd_score_q  <= score_mem[scan_idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
    end else if (cmd_i.scan_clr) begin
      scan_idx_q <= '0;
    end else if (rd_en) begin
      scan_idx_q <= scan_idx_q + IdxW'(1);
    end
  end

  // live flags
  logic [MAX_BOXES-1:0] live_q;

  // read-stage tags
  logic            rd_v_q, rd_pick_q;
  logic [IdxW-1:0] rd_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q    <= 1'b0;
      rd_pick_q <= 1'b0;
    end else begin
      rd_v_q    <= rd_en && live_q[scan_idx_q];
      rd_pick_q <= cmd_i.scan_pick;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= scan_idx_q;
  end

  // best-score search, ties go to the later box
  logic              found_q;
  logic [IdxW-1:0]   best_idx_q;
  logic [ScoreW-1:0] best_score_q;
  corners_t          best_box_q;
  logic              take_best;

  assign take_best = rd_v_q && rd_pick_q && (!found_q || rd_score_q >= best_score_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.pick_start) begin
      found_q <= 1'b0;
    end else if (take_best) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_best) begin
      best_idx_q   <= rd_idx_q;
      best_score_q <= rd_score_q;
      best_box_q   <= rd_corner_q;
    end
  end

  // picked box area, taken once per round
  logic signed [17:0] bw, bh;
  logic signed [35:0] ap_q;

  assign bw = 18'(best_box_q.box_x2) - 18'(best_box_q.box_x1) + 18'sd1;
  assign bh = 18'(best_box_q.box_y2) - 18'(best_box_q.box_y1) + 18'sd1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      ap_q <= bw * bh;
    end
  end

  // overlap pipeline, stage 1: clamped intersection extents, candidate extents
  logic signed [CoordW-1:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [17:0]       iw_s, ih_s, jw_d, jh_d;
  logic [16:0]              iw_q, ih_q;
  logic signed [17:0]       jw_q, jh_q;
  logic                     v1_q, v2_q, v3_q, v4_q;
  logic [IdxW-1:0]          idx1_q, idx2_q, idx3_q, idx4_q;

  always_comb begin
    lo_x = (best_box_q.box_x1 > rd_corner_q.box_x1) ? best_box_q.box_x1 : rd_corner_q.box_x1;
    hi_x = (best_box_q.box_x2 < rd_corner_q.box_x2) ? best_box_q.box_x2 : rd_corner_q.box_x2;
    lo_y = (best_box_q.box_y1 > rd_corner_q.box_y1) ? best_box_q.box_y1 : rd_corner_q.box_y1;
    hi_y = (best_box_q.box_y2 < rd_corner_q.box_y2) ? best_box_q.box_y2 : rd_corner_q.box_y2;
    iw_s = 18'(hi_x) - 18'(lo_x) + 18'sd1;
    ih_s = 18'(hi_y) - 18'(lo_y) + 18'sd1;
    jw_d = 18'(rd_corner_q.box_x2) - 18'(rd_corner_q.box_x1) + 18'sd1;
    jh_d = 18'(rd_corner_q.box_y2) - 18'(rd_corner_q.box_y1) + 18'sd1;
  end

  always_ff @(posedge clk_i) begin
    iw_q   <= iw_s[17] ? '0 : iw_s[16:0];
    ih_q   <= ih_s[17] ? '0 : ih_s[16:0];
    jw_q   <= jw_d;
    jh_q   <= jh_d;
    idx1_q <= rd_idx_q;
  end

  // stage 2: intersection and candidate area
  logic [33:0]        inter_q;
  logic signed [35:0] aj_q;

  always_ff @(posedge clk_i) begin
    inter_q <= iw_q * ih_q;
    aj_q    <= jw_q * jh_q;
    idx2_q  <= idx1_q;
  end

  // stage 3: denominator, scaled intersection
  logic signed [36:0] den_d, den_q;
  logic [49:0]        lhs3_q, lhs4_q;

  always_comb begin
    if (mode_q) begin
      den_d = (ap_q < aj_q) ? 37'(ap_q) : 37'(aj_q);
    end else begin
      den_d = 37'(ap_q) + 37'(aj_q) - $signed(37'(inter_q));
    end
  end

  always_ff @(posedge clk_i) begin
    den_q  <= den_d;
    lhs3_q <= {inter_q, 16'b0};
    idx3_q <= idx2_q;
  end

  // stage 4: threshold times denominator
  logic signed [53:0] rhs_q;
  logic               sup;

  always_ff @(posedge clk_i) begin
    rhs_q  <= $signed({1'b0, thr_q}) * den_q;
    lhs4_q <= lhs3_q;
    idx4_q <= idx3_q;
  end

  assign sup = $signed({4'b0, lhs4_q}) > rhs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= rd_v_q && !rd_pick_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // live flag updates and survivor tracking
  logic any_left_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
    end else if (cmd_i.end_set) begin
      live_q <= '0;
    end else begin
      if (wr_en) begin
        live_q[wr_idx] <= 1'b1;
      end
      if (cmd_i.prep) begin
        live_q[best_idx_q] <= 1'b0;
      end
      if (v4_q && sup) begin
        live_q[idx4_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_left_q <= 1'b0;
    end else if (cmd_i.prep) begin
      any_left_q <= 1'b0;
    end else if (v4_q && !sup) begin
      any_left_q <= 1'b1;
    end
  end

  // result beat register
  logic      out_valid_q;
  pick_out_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q.picked_index <= PickIdxW'(best_idx_q);
      out_data_q.picked_last  <= !any_left_q;
      out_data_q.overflow     <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign stat_o.scan_end = (CntW'(scan_idx_q) + CntW'(1) == count_q);
  assign stat_o.busy     = rd_v_q || v1_q || v2_q || v3_q || v4_q;
  assign stat_o.any_left = any_left_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result beat loaded over a pending one");

  a_pick_not_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !live_q[best_idx_q])
    else $error("picked box still live at emit");

  a_final_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && !any_left_q) |-> (live_q == '0))
    else $error("live boxes remain on final pick");

  a_prep_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.prep |-> (!stat_o.busy && found_q))
    else $error("round prep before search drained");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_BOXES))
    else $error("box count past capacity");

endmodule

// File: src/greedy_box_nms.sv
// Channel  Dir  Handshake              Payload
// in       in   in_valid_i/in_ready_o  in_data_i   (box_in_t, one box per beat)
// out      out  out_valid_o/out_ready_i out_data_o (pick_out_t, one kept box per beat)
// cfg      in   cfg_we_i               cfg_index_i, cfg_data_i (no read-back)
//
// Loading keeps in_ready_o high, so a new box can be taken on each beat. After the box
// marked last, each round for N stored boxes runs a score scan and an overlap scan at one
// store read per cycle through the single read port, plus prep, emit and a drain after each scan.
// Reset clears control, counts, live flags and config; box stores are not reset.
// The box marked last is taken at once; input then stays blocked until the final pick
// is loaded into the output register. A stalled output holds the round in its emit step.
module greedy_box_nms #(
  parameter int MAX_BOXES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  gbn_pkg::box_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output gbn_pkg::pick_out_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [gbn_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gbn_pkg::CfgDataW-1:0]  cfg_data_i
);
  import gbn_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  gbn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.box_last),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gbn_dp #(
    .MAX_BOXES (MAX_BOXES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
